@@ rtl/tsbe_pkg.sv @@
package tsbe_pkg;

  // Telnet protocol bytes
  localparam logic [7:0] B_NUL   = 8'h00;
  localparam logic [7:0] B_BEL   = 8'h07;
  localparam logic [7:0] B_LF    = 8'h0A;
  localparam logic [7:0] B_CR    = 8'h0D;
  localparam logic [7:0] B_DEL   = 8'h7F;
  localparam logic [7:0] B_OBRK  = 8'h81;
  localparam logic [7:0] B_OGREET = 8'h83;
  localparam logic [7:0] B_OECHOF = 8'h83;
  localparam logic [7:0] B_OECHON = 8'h84;
  localparam logic [7:0] B_SE    = 8'hF0;
  localparam logic [7:0] B_BREAK = 8'hF3;
  localparam logic [7:0] B_IP    = 8'hF4;
  localparam logic [7:0] B_AYT   = 8'hF6;
  localparam logic [7:0] B_EC    = 8'hF7;
  localparam logic [7:0] B_EL    = 8'hF8;
  localparam logic [7:0] B_SB    = 8'hFA;
  localparam logic [7:0] B_WILL  = 8'hFB;
  localparam logic [7:0] B_WONT  = 8'hFC;
  localparam logic [7:0] B_DO    = 8'hFD;
  localparam logic [7:0] B_DONT  = 8'hFE;
  localparam logic [7:0] B_IAC   = 8'hFF;
  localparam logic [7:0] OPT_ECHO = 8'h01;

  // Register indexes (word address bits)
  localparam logic [1:0] REG_RAW_MODE     = 2'd0;
  localparam logic [1:0] REG_ERASE_CHAR   = 2'd1;
  localparam logic [1:0] REG_KILL_CHAR    = 2'd2;
  localparam logic [1:0] REG_OLD_PROTOCOL = 2'd3;

  localparam logic [7:0] ERASE_RESET = 8'd35;
  localparam logic [7:0] KILL_RESET  = 8'd64;

  // Results per input item and queue depth
  localparam int MAX_RES   = 5;
  localparam int CNT_W     = 3;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;

  typedef enum logic [1:0] {
    ACT_NET   = 2'd0,
    ACT_TERM  = 2'd1,
    ACT_START = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    DST_TERM = 2'd0,
    DST_NET  = 2'd1,
    DST_ECHO = 2'd2
  } dst_t;

  typedef enum logic [1:0] {
    VERB_WILL = 2'd0,
    VERB_WONT = 2'd1,
    VERB_DO   = 2'd2,
    VERB_DONT = 2'd3
  } verb_t;

  typedef enum logic [2:0] {
    PH_DATA   = 3'd0,
    PH_CR     = 3'd1,
    PH_IAC    = 3'd2,
    PH_VERB   = 3'd3,
    PH_SB     = 3'd4,
    PH_SB_IAC = 3'd5
  } phase_t;

  typedef struct packed {
    logic       raw_mode;
    logic [7:0] erase_char;
    logic [7:0] kill_char;
    logic       old_protocol;
  } cfg_t;

  typedef struct packed {
    dst_t       dst;
    logic [7:0] val;
  } res_t;

  // All results caused by one input item
  typedef struct packed {
    logic [CNT_W-1:0]   cnt;
    res_t [MAX_RES-1:0] res;
  } desc_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

@@ rtl/tsbe_front.sv @@
module tsbe_front import tsbe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  input  logic [7:0] in_byte,
  input  q_stat_t    q_stat,
  output logic       in_ready,
  output logic       push,
  output desc_t      push_desc
);

  phase_t phase, phase_next;
  verb_t  verb, verb_next;
  logic   echo_answered, echo_answered_next;
  logic   accept;
  desc_t  d;
  logic [7:0] brk;
  logic [7:0] vdiff;
  logic [7:0] reply;
  logic       echo_on;

  // Append one result to a descriptor
  function automatic desc_t put(desc_t di, dst_t dst, logic [7:0] val);
    desc_t r;
    r = di;
    r.res[r.cnt] = '{dst: dst, val: val};
    r.cnt = r.cnt + CNT_W'(1);
    return r;
  endfunction

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DATA;
      verb          <= VERB_WILL;
      echo_answered <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      verb          <= verb_next;
      echo_answered <= echo_answered_next;
    end
  end

  // Classify the item and build its results
  always_comb begin
    d                  = '0;
    phase_next         = phase;
    verb_next          = verb;
    echo_answered_next = echo_answered;
    brk     = cfg.raw_mode ? B_NUL : B_DEL;
    vdiff   = in_byte - B_WILL;
    reply   = (verb == VERB_WILL || verb == VERB_WONT) ? B_DONT : B_WONT;
    echo_on = (verb == VERB_DO);
    unique case (in_action)
      ACT_NET: begin
        unique case (phase)
          PH_CR: begin
            if (in_byte != B_NUL && in_byte != B_LF) d = put(d, DST_TERM, in_byte);
            phase_next = PH_DATA;
          end
          PH_IAC: begin
            phase_next = PH_DATA;
            if (in_byte == B_BREAK || in_byte == B_IP) begin
              d = put(d, DST_TERM, brk);
            end else if (in_byte == B_AYT) begin
              d = put(d, DST_NET, B_BEL);
            end else if (in_byte == B_EC) begin
              d = put(d, DST_TERM, cfg.erase_char);
            end else if (in_byte == B_EL) begin
              d = put(d, DST_TERM, cfg.kill_char);
            end else if (in_byte == B_SB) begin
              phase_next = PH_SB;
            end else if (in_byte >= B_WILL && in_byte <= B_DONT) begin
              verb_next  = verb_t'(vdiff[1:0]);
              phase_next = PH_VERB;
            end else if (in_byte == B_IAC) begin
              d = put(d, DST_TERM, B_IAC);
            end
          end
          PH_VERB: begin
            phase_next = PH_DATA;
            if (in_byte == OPT_ECHO && reply == B_WONT) begin
              d = put(d, DST_ECHO, {7'd0, echo_on});
              if (!echo_answered) begin
                echo_answered_next = 1'b1;
              end else begin
                d = put(d, DST_NET, B_IAC);
                d = put(d, DST_NET, echo_on ? B_WILL : B_WONT);
                d = put(d, DST_NET, in_byte);
              end
            end else begin
              d = put(d, DST_NET, B_IAC);
              d = put(d, DST_NET, reply);
              d = put(d, DST_NET, in_byte);
            end
          end
          PH_SB: begin
            if (in_byte == B_IAC) phase_next = PH_SB_IAC;
          end
          PH_SB_IAC: begin
            phase_next = (in_byte == B_SE) ? PH_DATA : PH_SB;
          end
          default: begin
            phase_next = PH_DATA;
            if (in_byte == B_IAC) begin
              phase_next = PH_IAC;
            end else if (cfg.old_protocol && in_byte[7]) begin
              if (in_byte == B_OBRK) d = put(d, DST_TERM, brk);
              else if (in_byte == B_OECHOF) d = put(d, DST_ECHO, 8'd0);
              else if (in_byte == B_OECHON) d = put(d, DST_ECHO, 8'd1);
            end else begin
              d = put(d, DST_TERM, in_byte);
              if (in_byte == B_CR) phase_next = PH_CR;
            end
          end
        endcase
      end
      ACT_TERM: begin
        if (in_byte == B_IAC) begin
          d = put(d, DST_NET, B_IAC);
          d = put(d, DST_NET, B_IAC);
        end else if (in_byte != B_NUL) begin
          d = put(d, DST_NET, in_byte);
        end
      end
      ACT_START: begin
        phase_next         = PH_DATA;
        verb_next          = VERB_WILL;
        echo_answered_next = 1'b0;
        if (cfg.old_protocol) begin
          d = put(d, DST_NET, B_OGREET);
        end else begin
          d = put(d, DST_NET, B_IAC);
          d = put(d, DST_NET, B_WILL);
          d = put(d, DST_NET, OPT_ECHO);
        end
        d = put(d, DST_NET, B_CR);
        d = put(d, DST_NET, B_LF);
      end
      default: begin
        d = '0;
      end
    endcase
  end

  // Queue only items that cause results
  assign push      = accept && (d.cnt != '0);
  assign push_desc = d;

endmodule

@@ rtl/tsbe_queue.sv @@
module tsbe_queue import tsbe_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  desc_t   push_desc,
  input  logic    pop,
  output desc_t   head,
  output q_stat_t stat
);

  desc_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  count;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + Q_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + Q_PTR_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Store descriptors
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_desc;
  end

  assign head       = entries[rd_ptr];
  assign stat.valid = (count != '0);
  assign stat.full  = (count == Q_CNT_W'(Q_DEPTH));

endmodule

@@ rtl/tsbe_back.sv @@
module tsbe_back import tsbe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  desc_t      head,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_dst,
  output logic       out_last
);

  logic [CNT_W-1:0] idx;
  logic             load;
  logic             is_last;

  assign load    = q_stat.valid && (!out_valid || out_ready);
  assign is_last = (idx == head.cnt - CNT_W'(1));
  assign pop     = load && is_last;

  // Step through the results of the head descriptor
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= is_last ? '0 : idx + CNT_W'(1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the output transaction until taken
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head.res[idx].val;
      out_dst  <= head.res[idx].dst;
      out_last <= is_last;
    end
  end

endmodule

@@ rtl/telnet_server_byte_engine.sv @@
// Telnet server byte engine.
// Input stream (s_*): tuser carries the action (0 network byte, 1 terminal
// byte, 2 connection start), tdata the byte. A network byte is parsed for
// CR handling, IAC commands, option negotiation and subnegotiation; a
// terminal byte goes to the network with IAC doubled and NUL dropped; a
// connection start resets the parser and sends the greeting.
// Output stream (m_*): tuser is the destination (0 terminal, 1 network,
// 2 echo control), tdata the byte, tlast marks the final result of an item.
// Items that cause no result produce no output transaction.
// Timing: an accepted item is classified in its accept cycle and queued in
// a four-entry descriptor queue; the output stage then registers its results.
// The output stage issues one result per cycle while m_tready is high, so
// one-result items run at one item per cycle; an item's results go out in order.
// When m_tready is low the queue keeps taking items until it holds four,
// then s_tready drops. Synchronous reset empties the queue and output stage,
// returns the parser to the data phase and restores register defaults.
// Registers (APB, byte addresses 0, 4, 8, 12): raw_mode, erase_char,
// kill_char, old_protocol; write only while the engine is idle.
module telnet_server_byte_engine import tsbe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic [1:0]  m_tuser,   // [1:0] destination
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  logic    cfg_wr;
  logic    push;
  logic    pop;
  desc_t   push_desc;
  desc_t   head;
  q_stat_t q_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.raw_mode     <= 1'b0;
      cfg.erase_char   <= ERASE_RESET;
      cfg.kill_char    <= KILL_RESET;
      cfg.old_protocol <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RAW_MODE:     cfg.raw_mode     <= pwdata[0];
        REG_ERASE_CHAR:   cfg.erase_char   <= pwdata[7:0];
        REG_KILL_CHAR:    cfg.kill_char    <= pwdata[7:0];
        REG_OLD_PROTOCOL: cfg.old_protocol <= pwdata[0];
        default:          cfg.raw_mode     <= cfg.raw_mode;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (paddr[3:2])
      REG_RAW_MODE:     prdata = {31'd0, cfg.raw_mode};
      REG_ERASE_CHAR:   prdata = {24'd0, cfg.erase_char};
      REG_KILL_CHAR:    prdata = {24'd0, cfg.kill_char};
      REG_OLD_PROTOCOL: prdata = {31'd0, cfg.old_protocol};
      default:          prdata = '0;
    endcase
  end

  tsbe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_action (s_tuser),
    .in_byte   (s_tdata),
    .q_stat    (q_stat),
    .in_ready  (s_tready),
    .push      (push),
    .push_desc (push_desc)
  );

  tsbe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  tsbe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_dst   (m_tuser),
    .out_last  (m_tlast)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import tsbe_pkg::*;

  // Codes that the package does not name
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [7:0] ECHO_OFF = 8'd0;
  localparam logic [7:0] ECHO_ON  = 8'd1;

  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    dst_t       dst;
    logic [7:0] val;
    logic       last;
  } reply_t;

  // Mirrors the parser state and registers and holds the replies still owed
  class telnet_reply_tracker;
    logic       raw_mode;
    logic [7:0] erase_char;
    logic [7:0] kill_char;
    logic       old_protocol;
    phase_t     phase;
    verb_t      verb;
    logic       echo_answered;
    reply_t     replies[$];
    reply_t     fresh[$];
    int         errors;
    int         results_seen;
    int         echo_seen;
    int         items_by_action[4];

    function new();
      raw_mode      = 1'b0;
      erase_char    = ERASE_RESET;
      kill_char     = KILL_RESET;
      old_protocol  = 1'b0;
      phase         = PH_DATA;
      verb          = VERB_WILL;
      echo_answered = 1'b0;
      errors        = 0;
      results_seen  = 0;
      echo_seen     = 0;
      foreach (items_by_action[i]) items_by_action[i] = 0;
    endfunction

    function void load_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_RAW_MODE:     raw_mode = v[0];
        REG_ERASE_CHAR:   erase_char = v[7:0];
        REG_KILL_CHAR:    kill_char = v[7:0];
        REG_OLD_PROTOCOL: old_protocol = v[0];
        default: ;
      endcase
    endfunction

    function void put(dst_t d, logic [7:0] v);
      fresh.push_back('{dst: d, val: v, last: 1'b0});
    endfunction

    function logic [7:0] break_char();
      return raw_mode ? B_NUL : B_DEL;
    endfunction

    // Refuse options, except a DO for ECHO which is accepted; first echo reply goes unanswered
    function void answer_option(logic [7:0] opt);
      logic [7:0] reply;
      reply = (verb == VERB_WILL || verb == VERB_WONT) ? B_DONT : B_WONT;
      if (opt == OPT_ECHO && reply == B_WONT) begin
        if (verb == VERB_DO) begin
          put(DST_ECHO, ECHO_ON);
          reply = B_WILL;
        end else begin
          put(DST_ECHO, ECHO_OFF);
        end
        if (!echo_answered) begin
          echo_answered = 1'b1;
          return;
        end
      end
      put(DST_NET, B_IAC);
      put(DST_NET, reply);
      put(DST_NET, opt);
    endfunction

    // Byte following IAC
    function void decode_command(logic [7:0] c);
      logic [7:0] d;
      phase = PH_DATA;
      if (c == B_BREAK || c == B_IP) begin
        put(DST_TERM, break_char());
      end else if (c == B_AYT) begin
        put(DST_NET, B_BEL);
      end else if (c == B_EC) begin
        put(DST_TERM, erase_char);
      end else if (c == B_EL) begin
        put(DST_TERM, kill_char);
      end else if (c == B_SB) begin
        phase = PH_SB;
      end else if (c >= B_WILL && c <= B_DONT) begin
        d = c - B_WILL;
        verb = verb_t'(d[1:0]);
        phase = PH_VERB;
      end else if (c == B_IAC) begin
        put(DST_TERM, B_IAC);
      end
    endfunction

    function void network_byte(logic [7:0] c);
      case (phase)
        PH_CR: begin
          if (c != B_NUL && c != B_LF) put(DST_TERM, c);
          phase = PH_DATA;
        end
        PH_IAC: decode_command(c);
        PH_VERB: begin
          answer_option(c);
          phase = PH_DATA;
        end
        PH_SB: begin
          if (c == B_IAC) phase = PH_SB_IAC;
        end
        PH_SB_IAC: phase = (c == B_SE) ? PH_DATA : PH_SB;
        default: begin
          phase = PH_DATA;
          if (c == B_IAC) begin
            phase = PH_IAC;
          end else if (old_protocol && c[7]) begin
            if (c == B_OBRK) put(DST_TERM, break_char());
            else if (c == B_OECHOF) put(DST_ECHO, ECHO_OFF);
            else if (c == B_OECHON) put(DST_ECHO, ECHO_ON);
          end else begin
            put(DST_TERM, c);
            if (c == B_CR) phase = PH_CR;
          end
        end
      endcase
    endfunction

    // Work out the replies of one accepted input transaction
    function void take_item(logic [1:0] act, logic [7:0] b);
      fresh.delete();
      items_by_action[act]++;
      case (act)
        ACT_NET: network_byte(b);
        ACT_TERM: begin
          if (b == B_IAC) begin
            put(DST_NET, B_IAC);
            put(DST_NET, B_IAC);
          end else if (b != B_NUL) begin
            put(DST_NET, b);
          end
        end
        ACT_START: begin
          phase = PH_DATA;
          verb = VERB_WILL;
          echo_answered = 1'b0;
          if (old_protocol) begin
            put(DST_NET, B_OGREET);
          end else begin
            put(DST_NET, B_IAC);
            put(DST_NET, B_WILL);
            put(DST_NET, OPT_ECHO);
          end
          put(DST_NET, B_CR);
          put(DST_NET, B_LF);
        end
        default: ;
      endcase
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) replies.push_back(fresh[i]);
    endfunction

    function void note_mismatch(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    // Compare one output transaction with the oldest reply owed
    function void match_result(logic [1:0] d, logic [7:0] v, logic l);
      reply_t want;
      results_seen++;
      if (replies.size() == 0) begin
        note_mismatch($sformatf("unexpected result dst=%0d byte=%02h last=%0d", d, v, l));
        return;
      end
      want = replies.pop_front();
      if (want.dst == DST_ECHO) echo_seen++;
      if (d != want.dst || v != want.val || l != want.last)
        note_mismatch($sformatf(
          "result %0d: expected dst=%0d byte=%02h last=%0d, got dst=%0d byte=%02h last=%0d",
          results_seen, want.dst, want.val, want.last, d, v, l));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  telnet_reply_tracker board = new();

  int   burst_left = 0;
  int   items_sent = 0;
  int   settings_used = 0;
  logic hold_off_req = 1'b0;

  telnet_server_byte_engine u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Watch both streams; results are checked before the new input is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.match_result(m_tuser, m_tdata, m_tlast);
      if (s_tvalid && s_tready) board.take_item(s_tuser, s_tdata);
    end
  end

  // Receiver: segments of its own stall pattern, plus a long hold-off on request
  initial begin : rx_side
    int mode;
    int span;
    int tick;
    m_tready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 40);
      for (tick = 0; tick < span; tick++) begin
        @(posedge clk);
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          m_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else begin
          case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (tick % 3 == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one input transaction, opening a new burst after a random gap
  task automatic offer(input logic [1:0] act, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    if (act != ACT_NONE) items_sent++;
  endtask

  // Stop sending until every reply is in, then let the engine settle
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (board.replies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.load_reg(idx, v);
  endtask

  task automatic set_all(input logic raw, input logic [7:0] er, input logic [7:0] kl,
                         input logic old);
    drain();
    apb_write(REG_RAW_MODE, {31'd0, raw});
    apb_write(REG_ERASE_CHAR, {24'd0, er});
    apb_write(REG_KILL_CHAR, {24'd0, kl});
    apb_write(REG_OLD_PROTOCOL, {31'd0, old});
    settings_used++;
  endtask

  // Mostly well-formed Telnet sequences with random content, some noise
  task automatic offer_sequence();
    int pick;
    int n;
    int k;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      offer(ACT_NET, rand_byte());
    end else if (pick < 40) begin
      offer(ACT_NET, B_CR);
      case ($urandom_range(0, 2))
        0: b = B_LF;
        1: b = B_NUL;
        default: b = rand_byte();
      endcase
      offer(ACT_NET, b);
    end else if (pick < 55) begin
      case ($urandom_range(0, 8))
        0: b = B_BREAK;
        1: b = B_IP;
        2: b = B_AYT;
        3: b = B_EC;
        4: b = B_EL;
        5: b = B_IAC;
        6: b = B_SE;
        7: b = B_SE | 8'($urandom_range(0, 15));
        default: b = rand_byte();
      endcase
      offer(ACT_NET, B_IAC);
      offer(ACT_NET, b);
    end else if (pick < 70) begin
      offer(ACT_NET, B_IAC);
      offer(ACT_NET, 8'(B_WILL + $urandom_range(0, 3)));
      offer(ACT_NET, $urandom_range(0, 1) ? OPT_ECHO : rand_byte());
    end else if (pick < 78) begin
      offer(ACT_NET, B_IAC);
      offer(ACT_NET, B_SB);
      n = $urandom_range(0, 4);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          b = rand_byte();
          offer(ACT_NET, B_IAC);
          offer(ACT_NET, (b == B_SE) ? B_SB : b);
        end else begin
          offer(ACT_NET, rand_byte());
        end
      end
      offer(ACT_NET, B_IAC);
      offer(ACT_NET, B_SE);
    end else if (pick < 90) begin
      case ($urandom_range(0, 7))
        0, 1: b = B_IAC;
        2: b = B_NUL;
        default: b = rand_byte();
      endcase
      offer(ACT_TERM, b);
    end else if (pick < 93) begin
      offer(ACT_START, rand_byte());
    end else begin
      offer(2'($urandom_range(0, 3)), rand_byte());
    end
  endtask

  task automatic random_run(input int target, input bit long_hold, input bit mid_pause);
    items_sent = 0;
    if (long_hold) hold_off_req = 1'b1;
    while (items_sent < target) begin
      offer_sequence();
      if (mid_pause && items_sent >= target / 2) begin
        drain();
        mid_pause = 1'b0;
      end
    end
  endtask

  initial begin
    #2000000;
    $display("telnet_server_byte_engine: mismatch");
    $finish;
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'd0;
    s_tuser  <= ACT_NET;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= 4'd0;
    pwdata   <= 32'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default terminal: greeting, CR handling, IAC commands, subnegotiation, echo
    set_all(1'b0, ERASE_RESET, KILL_RESET, 1'b0);
    offer(ACT_START, 8'h00);
    offer(ACT_NET, B_CR);    offer(ACT_NET, B_LF);
    offer(ACT_NET, B_CR);    offer(ACT_NET, B_NUL);
    offer(ACT_NET, B_CR);    offer(ACT_NET, B_IAC);
    offer(ACT_NET, B_IAC);   offer(ACT_NET, B_BREAK);
    offer(ACT_NET, B_IAC);   offer(ACT_NET, B_EC);
    offer(ACT_NET, B_IAC);   offer(ACT_NET, B_EL);
    offer(ACT_NET, B_IAC);   offer(ACT_NET, B_IAC);
    offer(ACT_NET, B_IAC);   offer(ACT_NET, B_SB);
    offer(ACT_NET, 8'h41);   offer(ACT_NET, B_IAC);
    offer(ACT_NET, OPT_ECHO); offer(ACT_NET, B_IAC);
    offer(ACT_NET, B_SE);
    offer(ACT_NET, B_IAC);   offer(ACT_NET, B_DO);    offer(ACT_NET, OPT_ECHO);
    random_run(80, 1'b1, 1'b0);

    // Raw mode with old single-byte commands and extreme edit characters
    set_all(1'b1, 8'h00, 8'hFF, 1'b1);
    offer(ACT_NET, B_IAC);   offer(ACT_NET, B_IP);
    offer(ACT_NET, B_IAC);   offer(ACT_NET, B_AYT);
    offer(ACT_NET, B_IAC);   offer(ACT_NET, B_DONT);  offer(ACT_NET, OPT_ECHO);
    offer(ACT_NET, B_IAC);   offer(ACT_NET, B_WILL);  offer(ACT_NET, 8'h05);
    offer(ACT_NET, B_IAC);   offer(ACT_NET, 8'hF1);
    offer(ACT_NET, B_OBRK);  offer(ACT_NET, 8'h82);
    offer(ACT_NET, B_OECHOF); offer(ACT_NET, B_OECHON);
    offer(ACT_NET, B_CR);    offer(ACT_NET, 8'h80);
    offer(ACT_TERM, B_IAC);  offer(ACT_TERM, B_NUL);
    offer(ACT_START, 8'hFF);
    offer(ACT_NONE, 8'hA5);
    random_run(80, 1'b0, 1'b0);

    // Opposite extremes, with a full pause midway
    set_all(1'b0, 8'hFF, 8'h00, 1'b0);
    random_run(80, 1'b0, 1'b1);

    // Random settings
    set_all(1'($urandom_range(0, 1)), rand_byte(), rand_byte(), 1'($urandom_range(0, 1)));
    random_run(95, 1'b1, 1'b0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d network, %0d terminal, %0d start and %0d ignored items",
             board.items_by_action[ACT_NET], board.items_by_action[ACT_TERM],
             board.items_by_action[ACT_START], board.items_by_action[ACT_NONE]);
    $display("%0d results checked (%0d echo control) over %0d register settings",
             board.results_seen, board.echo_seen, settings_used);
    if (board.errors > REPORT_LIMIT)
      $display("%0d further mismatches not shown", board.errors - REPORT_LIMIT);
    if (board.replies.size() != 0)
      $display("%0d expected results never arrived", board.replies.size());
    if (board.errors == 0 && board.replies.size() == 0)
      $display("telnet_server_byte_engine: match");
    else
      $display("telnet_server_byte_engine: mismatch");
    $finish;
  end

endmodule
